// ===== rtl/ocrd_pkg.sv =====
// ----------------------------------------------------------------------------
// ocrd_pkg: shared constants and types of the operation-class delay block
// Generator constants, class codes, register indexes and field widths.
// ----------------------------------------------------------------------------
package ocrd_pkg;

   localparam int STATE_W    = 64;
   localparam int BOUND_W    = 59;
   localparam int ID_W       = 32;
   localparam int SIZE_W     = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int MUL_BITS   = 31;
   localparam int MUL_CNT_W  = 5;
   localparam int DIV_CNT_W  = 6;

   localparam int CLASS_SPAN_DEF = 256;

   localparam logic [MUL_BITS-1:0] LCG_MUL = 31'd1103515245;
   localparam logic [STATE_W-1:0]  LCG_ADD = 64'd12345;

   localparam logic [BOUND_W-1:0] FAST_BOUND   = 59'd5;
   localparam logic [BOUND_W-1:0] MEDIUM_BOUND = 59'd10;
   localparam int                 ALLOC_SHIFT  = 6;

   // Class codes
   localparam logic [1:0] CLASS_FAST   = 2'd0;
   localparam logic [1:0] CLASS_MEDIUM = 2'd1;
   localparam logic [1:0] CLASS_ALLOC  = 2'd2;
   localparam logic [1:0] CLASS_OTHER  = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SEED      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INTENSITY = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FAST      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MEDIUM    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ALLOC     = 3'd4;

   // Reset values
   localparam logic [STATE_W-1:0] SEED_RST      = 64'd1;
   localparam logic [ID_W-1:0]    INTENSITY_RST = 32'd10;
   localparam logic [ID_W-1:0]    FAST_RST      = 32'd256;
   localparam logic [ID_W-1:0]    MEDIUM_RST    = 32'd512;
   localparam logic [ID_W-1:0]    ALLOC_RST     = 32'd768;

   // Control toward the generator
   typedef struct packed {
      logic                 start;
      logic                 load;
      logic [STATE_W-1:0]   load_value;
   } lcg_ctrl_type;

   // Status back from a serial unit
   typedef struct packed {
      logic done;
   } unit_status_type;

endpackage

// ===== rtl/op_class_random_delay.sv =====
// ----------------------------------------------------------------------------
// op_class_random_delay: per-operation pseudo-random delay by operation class
// Each request goes from acceptance to a result in these steps: a start
// step, the bit-serial generator multiply (one bit of the constant
// multiplier per cycle), the bit-serial remainder (one dividend bit per
// cycle) and the step that hands the result on to the
// output register. One request is worked on at a time; req_stall stays high
// while it is in flight, and a finished result waits in the output register
// so the next request can be taken while the consumer stalls. The generator
// advances state*1103515245+12345 (mod 2^64); the delay is the new state
// modulo a class bound, plus one. Ids in the fast window get bound 5, the
// medium window 10, the allocation window (request size in bytes)/64+1,
// everything else the intensity register (zero acts as one). Windows are
// CLASS_SPAN ids wide, checked fast, medium, allocation in that order, and do
// not wrap past the top of the id range. Writing the seed reloads the
// generator at once; a request marked last reloads it after its result is
// produced. Write the registers only while the block is idle.
// ----------------------------------------------------------------------------
module op_class_random_delay #(
   parameter int CLASS_SPAN = ocrd_pkg::CLASS_SPAN_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [ocrd_pkg::ID_W-1:0]            req_op_id,
   input  logic [ocrd_pkg::SIZE_W-1:0]          req_size_bytes,
   input  logic                                 req_last_in_sequence,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [ocrd_pkg::BOUND_W-1:0]         rsp_delay,
   output logic [1:0]                           rsp_op_class,

   input  logic                                 csr_write_en,
   input  logic [ocrd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ocrd_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   localparam logic [ocrd_pkg::ID_W-1:0] SPAN_W = ocrd_pkg::ID_W'(CLASS_SPAN);

   // Sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   // Configuration registers
   logic [ocrd_pkg::STATE_W-1:0] seed_ff;
   logic [ocrd_pkg::ID_W-1:0]    intensity_ff;
   logic [ocrd_pkg::ID_W-1:0]    fast_base_ff;
   logic [ocrd_pkg::ID_W-1:0]    medium_base_ff;
   logic [ocrd_pkg::ID_W-1:0]    alloc_base_ff;

   // Captured request
   logic [ocrd_pkg::ID_W-1:0]    op_id_ff;
   logic [ocrd_pkg::SIZE_W-1:0]  size_ff;
   logic                         last_ff;
   logic [1:0]                   class_ff, class_in;

   logic [1:0]                   state_ff, state_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ocrd_pkg::BOUND_W-1:0] rsp_delay_ff;
   logic [1:0]                   rsp_class_ff;

   logic                         req_accept;
   logic                         out_load;
   logic                         seed_write;

   ocrd_pkg::lcg_ctrl_type       lcg_ctrl;
   ocrd_pkg::unit_status_type    lcg_status;
   ocrd_pkg::unit_status_type    mod_status;
   logic [ocrd_pkg::STATE_W-1:0] lcg_state;
   logic [ocrd_pkg::BOUND_W-1:0] mod_rem;
   logic                         mod_start;

   logic                         in_fast, in_medium, in_alloc;
   logic [ocrd_pkg::ID_W:0]      fast_off, medium_off, alloc_off;
   logic [ocrd_pkg::BOUND_W-1:0] bound;
   logic [ocrd_pkg::BOUND_W-1:0] alloc_bound;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign seed_write = csr_write_en && (csr_index == ocrd_pkg::REG_SEED);

   // Window test: id - base must not borrow and must stay below the span,
   // so a window near the top of the id range is cut off, not wrapped.
   assign fast_off   = {1'b0, op_id_ff} - {1'b0, fast_base_ff};
   assign medium_off = {1'b0, op_id_ff} - {1'b0, medium_base_ff};
   assign alloc_off  = {1'b0, op_id_ff} - {1'b0, alloc_base_ff};

   assign in_fast   = !fast_off[ocrd_pkg::ID_W]
                      && (fast_off[ocrd_pkg::ID_W-1:0] < SPAN_W);
   assign in_medium = !medium_off[ocrd_pkg::ID_W]
                      && (medium_off[ocrd_pkg::ID_W-1:0] < SPAN_W);
   assign in_alloc  = !alloc_off[ocrd_pkg::ID_W]
                      && (alloc_off[ocrd_pkg::ID_W-1:0] < SPAN_W);

   assign alloc_bound = {1'b0, size_ff[ocrd_pkg::SIZE_W-1:ocrd_pkg::ALLOC_SHIFT]}
                        + ocrd_pkg::BOUND_W'(1);

   // Pick the bound; first matching window wins
   always_comb begin
      if (in_fast) begin
         class_in = ocrd_pkg::CLASS_FAST;
         bound    = ocrd_pkg::FAST_BOUND;
      end else if (in_medium) begin
         class_in = ocrd_pkg::CLASS_MEDIUM;
         bound    = ocrd_pkg::MEDIUM_BOUND;
      end else if (in_alloc) begin
         class_in = ocrd_pkg::CLASS_ALLOC;
         bound    = alloc_bound;
      end else begin
         class_in = ocrd_pkg::CLASS_OTHER;
         // zero intensity acts as one
         bound    = (intensity_ff == '0) ? ocrd_pkg::BOUND_W'(1)
                                         : ocrd_pkg::BOUND_W'(intensity_ff);
      end
   end

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      mod_start = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // new generator state is ready: start the remainder
            if (lcg_status.done) begin
               mod_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (mod_status.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Generator control: advance on acceptance; reload on a seed write or
   // after the last request of a sequence.
   always_comb begin
      lcg_ctrl.start      = req_accept;
      lcg_ctrl.load       = seed_write || (out_load && last_ff);
      lcg_ctrl.load_value = seed_write ? csr_write_data : seed_ff;
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         seed_ff        <= ocrd_pkg::SEED_RST;
         intensity_ff   <= ocrd_pkg::INTENSITY_RST;
         fast_base_ff   <= ocrd_pkg::FAST_RST;
         medium_base_ff <= ocrd_pkg::MEDIUM_RST;
         alloc_base_ff  <= ocrd_pkg::ALLOC_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            case (csr_index)
               ocrd_pkg::REG_SEED:      seed_ff        <= csr_write_data;
               ocrd_pkg::REG_INTENSITY: intensity_ff   <= csr_write_data[ocrd_pkg::ID_W-1:0];
               ocrd_pkg::REG_FAST:      fast_base_ff   <= csr_write_data[ocrd_pkg::ID_W-1:0];
               ocrd_pkg::REG_MEDIUM:    medium_base_ff <= csr_write_data[ocrd_pkg::ID_W-1:0];
               ocrd_pkg::REG_ALLOC:     alloc_base_ff  <= csr_write_data[ocrd_pkg::ID_W-1:0];
               default: begin
               end
            endcase
         end
      end
      if (req_accept) begin
         op_id_ff <= req_op_id;
         size_ff  <= req_size_bytes;
         last_ff  <= req_last_in_sequence;
      end
      if (mod_start) begin
         class_ff <= class_in;
      end
      if (out_load) begin
         rsp_delay_ff <= mod_rem + ocrd_pkg::BOUND_W'(1);
         rsp_class_ff <= class_ff;
      end
   end

   ocrd_lcg u_lcg (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (lcg_ctrl),
      .status (lcg_status),
      .state  (lcg_state)
   );

   ocrd_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (lcg_state),
      .divisor   (bound),
      .status    (mod_status),
      .remainder (mod_rem)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_delay    = rsp_delay_ff;
   assign rsp_op_class = rsp_class_ff;

endmodule

// ===== rtl/ocrd_lcg.sv =====
// ----------------------------------------------------------------------------
// ocrd_lcg: bit-serial linear congruential generator
// Advances state = state * LCG_MUL + LCG_ADD (mod 2^64), one multiplier
// bit per cycle, shift-and-add over the MUL_BITS bits of the multiplier.
// ----------------------------------------------------------------------------
module ocrd_lcg (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ocrd_pkg::lcg_ctrl_type               ctrl,
   output ocrd_pkg::unit_status_type            status,
   output logic [ocrd_pkg::STATE_W-1:0]         state
);

   logic [ocrd_pkg::STATE_W-1:0]   state_ff, state_in;
   logic [ocrd_pkg::STATE_W-1:0]   acc_ff, acc_in;
   logic [ocrd_pkg::STATE_W-1:0]   mcand_ff, mcand_in;
   logic [ocrd_pkg::MUL_CNT_W-1:0] idx_ff, idx_in;
   logic                           run_ff, run_in;
   logic                           done_ff, done_in;
   logic [ocrd_pkg::STATE_W-1:0]   acc_step;
   logic                           last_bit;

   assign last_bit = (idx_ff == ocrd_pkg::MUL_CNT_W'(ocrd_pkg::MUL_BITS - 1));
   assign acc_step = ocrd_pkg::LCG_MUL[idx_ff] ? acc_ff + mcand_ff : acc_ff;

   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      idx_in   = idx_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (ctrl.start) begin
         // seed the accumulator with the increment
         acc_in   = ocrd_pkg::LCG_ADD;
         mcand_in = state_ff;
         idx_in   = '0;
         run_in   = 1'b1;
      end else if (run_ff) begin
         acc_in   = acc_step;
         mcand_in = {mcand_ff[ocrd_pkg::STATE_W-2:0], 1'b0};
         idx_in   = idx_ff + 1'b1;
         if (last_bit) begin
            state_in = acc_step;
            run_in   = 1'b0;
            done_in  = 1'b1;
         end
      end
      if (ctrl.load) begin
         state_in = ctrl.load_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ocrd_pkg::SEED_RST;
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         run_ff   <= run_in;
         done_ff  <= done_in;
         idx_ff   <= idx_in;
      end
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
   end

   assign state       = state_ff;
   assign status.done = done_ff;

endmodule

// ===== rtl/ocrd_mod.sv =====
// ----------------------------------------------------------------------------
// ocrd_mod: bit-serial remainder unit
// Restoring division of a 64-bit value by a 59-bit bound, one dividend bit
// per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module ocrd_mod (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [ocrd_pkg::STATE_W-1:0]         dividend,
   input  logic [ocrd_pkg::BOUND_W-1:0]         divisor,
   output ocrd_pkg::unit_status_type            status,
   output logic [ocrd_pkg::BOUND_W-1:0]         remainder
);

   logic [ocrd_pkg::STATE_W-1:0]   num_ff, num_in;
   logic [ocrd_pkg::BOUND_W-1:0]   rem_ff, rem_in;
   logic [ocrd_pkg::BOUND_W-1:0]   div_ff, div_in;
   logic [ocrd_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           run_ff, run_in;
   logic                           done_ff, done_in;
   logic [ocrd_pkg::BOUND_W:0]     trial;
   logic [ocrd_pkg::BOUND_W:0]     diff;
   logic                           fits;

   // bring down the next dividend bit and try a subtract
   assign trial = {rem_ff, num_ff[ocrd_pkg::STATE_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = (trial >= {1'b0, div_ff});

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         num_in = dividend;
         rem_in = '0;
         div_in = divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         num_in = {num_ff[ocrd_pkg::STATE_W-2:0], 1'b0};
         rem_in = fits ? diff[ocrd_pkg::BOUND_W-1:0] : trial[ocrd_pkg::BOUND_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (&cnt_ff) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign remainder   = rem_ff;
   assign status.done = done_ff;

endmodule
